[design/iut_pkg.sv]
// shared types and constants for the interval union table
package iut_pkg;

    localparam int ID_W           = 48;
    localparam int TOT_W          = ID_W + 1;
    localparam int CNT_OUT_W      = 9;
    localparam int DEF_MAX_RANGES = 256;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_REVERSED = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic [ID_W-1:0] range_low;
        logic [ID_W-1:0] range_high;
    } t_in;

    typedef struct packed {
        logic [TOT_W-1:0]     covered_total;
        logic [CNT_OUT_W-1:0] entry_count;
        t_status              status;
    } t_out;

    typedef struct packed {
        logic            valid;
        logic [ID_W-1:0] high;
        logic [ID_W-1:0] low;
    } t_entry;

endpackage

[design/iut_ram.sv]
// generic single write port, single read port ram with registered read
module iut_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/interval_union_table.sv]
// interval union table: keeps disjoint inclusive ranges and merges overlapping inserts
//
// Each request carries one inclusive range. The table lives in a single ram of
// MAX_RANGES entries; every insert sweeps all slots through the one read port, one
// slot a cycle, removing entries that overlap the new range (ranges that only touch
// stay apart) and writing the merged range into the lowest free slot. An insert
// goes through the scan, drain and finish states; a reversed range skips to finish.
// Results report the covered id count, the entry count and a status (accepted,
// dropped for full table, dropped for reversed range). After reset the block
// clears every ram slot and holds o_in_stall high meanwhile. The output register
// lets a finished result wait while the next request is taken.
module interval_union_table #(
    parameter int MAX_RANGES = iut_pkg::DEF_MAX_RANGES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  iut_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output iut_pkg::t_out o_out_data
);
    import iut_pkg::*;

    localparam int IDX_W = $clog2(MAX_RANGES);
    localparam int CNT_W = $clog2(MAX_RANGES + 1);
    localparam int ENT_W = $bits(t_entry);

    t_state              r_state, n_state;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic                r_pend, n_pend;
    logic [IDX_W-1:0]    r_pend_idx, n_pend_idx;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [TOT_W-1:0]    r_total, n_total;
    logic                r_out_valid, n_out_valid;
    logic                r_free_found, n_free_found;

    logic [ID_W-1:0]     r_lo, n_lo;
    logic [ID_W-1:0]     r_hi, n_hi;
    logic [ID_W-1:0]     r_new_lo, n_new_lo;
    logic [ID_W-1:0]     r_new_hi, n_new_hi;
    logic                r_rev, n_rev;
    logic [IDX_W-1:0]    r_free_idx, n_free_idx;
    t_out                r_out, n_out;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    t_entry              ram_wdata;
    logic                ram_re;
    logic [IDX_W-1:0]    ram_raddr;
    logic [ENT_W-1:0]    ram_rdata;

    t_entry              ent;
    logic                ovl;
    logic                out_free;
    logic [31:0]         cnt_wide;

    iut_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_RANGES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign ent      = t_entry'(ram_rdata);
    assign ovl      = ent.valid && (ent.low <= r_hi) && (ent.high >= r_lo);
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_pend       = 1'b0;
        n_pend_idx   = r_idx;
        n_count      = r_count;
        n_total      = r_total;
        n_out_valid  = r_out_valid && i_out_stall;
        n_free_found = r_free_found;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_new_lo     = r_new_lo;
        n_new_hi     = r_new_hi;
        n_rev        = r_rev;
        n_free_idx   = r_free_idx;
        n_out        = r_out;
        ram_we       = 1'b0;
        ram_waddr    = r_idx;
        ram_wdata    = '0;
        ram_re       = 1'b0;
        ram_raddr    = r_idx;
        cnt_wide     = '0;
        o_in_stall   = (r_state != S_IDLE);

        // slot read last cycle: drop it if it overlaps, note first free slot
        if (r_pend) begin
            if (ovl) begin
                n_new_lo  = (ent.low < r_new_lo) ? ent.low : r_new_lo;
                n_new_hi  = (ent.high > r_new_hi) ? ent.high : r_new_hi;
                // total - (high - low + 1) == total + low + ~high
                n_total   = r_total + TOT_W'(ent.low) + ~TOT_W'(ent.high);
                n_count   = r_count - CNT_W'(1);
                ram_we    = 1'b1;
                ram_waddr = r_pend_idx;
                ram_wdata = '{valid: 1'b0, high: ent.high, low: ent.low};
            end
            if ((!ent.valid || ovl) && !r_free_found) begin
                n_free_found = 1'b1;
                n_free_idx   = r_pend_idx;
            end
        end

        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = '0;
                n_idx     = r_idx + IDX_W'(1);
                if (r_idx == IDX_W'(MAX_RANGES - 1)) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_lo         = i_in_data.range_low;
                    n_hi         = i_in_data.range_high;
                    n_new_lo     = i_in_data.range_low;
                    n_new_hi     = i_in_data.range_high;
                    n_rev        = (i_in_data.range_low > i_in_data.range_high);
                    n_free_found = 1'b0;
                    n_idx        = '0;
                    n_state      = (i_in_data.range_low > i_in_data.range_high) ?
                                   S_FINISH : S_SCAN;
                end
            end
            S_SCAN: begin
                ram_re     = 1'b1;
                ram_raddr  = r_idx;
                n_pend     = 1'b1;
                n_pend_idx = r_idx;
                n_idx      = r_idx + IDX_W'(1);
                if (r_idx == IDX_W'(MAX_RANGES - 1)) begin
                    n_idx   = '0;
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) begin
                    n_out.status = ST_OK;
                    if (r_rev) begin
                        n_out.status = ST_REVERSED;
                    end else if (!r_free_found) begin
                        n_out.status = ST_FULL;
                    end else begin
                        ram_we    = 1'b1;
                        ram_waddr = r_free_idx;
                        ram_wdata = '{valid: 1'b1, high: r_new_hi, low: r_new_lo};
                        n_count   = r_count + CNT_W'(1);
                        n_total   = TOT_W'(r_total + TOT_W'(r_new_hi) - TOT_W'(r_new_lo)
                                    + TOT_W'(1));
                    end
                    cnt_wide            = 32'(n_count);
                    n_out.covered_total = n_total;
                    n_out.entry_count   = cnt_wide[CNT_OUT_W-1:0];
                    n_out_valid         = 1'b1;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_idx        <= '0;
            r_pend       <= 1'b0;
            r_count      <= '0;
            r_total      <= '0;
            r_out_valid  <= 1'b0;
            r_free_found <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_pend       <= n_pend;
            r_count      <= n_count;
            r_total      <= n_total;
            r_out_valid  <= n_out_valid;
            r_free_found <= n_free_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_idx <= n_pend_idx;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_new_lo   <= n_new_lo;
        r_new_hi   <= n_new_hi;
        r_rev      <= n_rev;
        r_free_idx <= n_free_idx;
        r_out      <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[test/tb.sv]
// testbench for the interval union table: directed and random range inserts
`timescale 1ns / 1ps

module tb;
    import iut_pkg::*;

    localparam int          SLOTS       = DEF_MAX_RANGES;
    localparam logic [47:0] ID_MAX      = {ID_W{1'b1}};
    localparam logic [47:0] FILL_BASE   = 48'hC001_0000_0000;
    localparam logic [47:0] FILL_STRIDE = 48'h1_0000;
    localparam int          FILL_CELLS  = 512;
    localparam int          IDLE_LIMIT  = 4000;
    localparam int          DRAIN_WAIT  = SLOTS + 40;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   i_in_valid = 1'b0;
    logic   o_in_stall;
    t_in    i_in_data = '0;
    logic   o_out_valid;
    logic   i_out_stall = 1'b0;
    t_out   o_out_data;

    // table as the block should hold it
    logic [47:0] tbl_lo [SLOTS];
    logic [47:0] tbl_hi [SLOTS];
    bit          tbl_used [SLOTS];
    logic [8:0]  n_entries = '0;
    logic [48:0] ids_covered = '0;

    t_out pending_reports [$];
    t_out got_report;
    int   err_count = 0;
    int   idle_cycles = 0;
    int   burst_left = 0;
    bit   stall_on = 1'b0;
    int   stall_run = 0;

    interval_union_table #(
        .MAX_RANGES(SLOTS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [48:0] id_span(input logic [47:0] lo, input logic [47:0] hi);
        return {1'b0, hi} - {1'b0, lo} + 49'd1;
    endfunction

    function automatic bit overlaps_slot(input int s, input logic [47:0] lo,
                                         input logic [47:0] hi);
        return tbl_used[s] && tbl_lo[s] <= hi && tbl_hi[s] >= lo;
    endfunction

    function automatic bit table_hit(input logic [47:0] lo, input logic [47:0] hi);
        int s;
        for (s = 0; s < SLOTS; s++) begin
            if (overlaps_slot(s, lo, hi)) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [47:0] rand_id();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[47:0];
    endfunction

    // keep random ranges out of the region reserved for filling the table
    function automatic logic [47:0] below_fill(input logic [47:0] v);
        if (v >= FILL_BASE - FILL_STRIDE) v[46] = 1'b0;
        return v;
    endfunction

    // apply one request to the table copy and work out its report
    task automatic merge_request(input t_in req, output t_out rep);
        logic [47:0] lo, hi, new_lo, new_hi;
        t_status     st;
        int          s, free_slot;
        lo = req.range_low;
        hi = req.range_high;
        if (lo > hi) begin
            st = ST_REVERSED;
        end else begin
            new_lo = lo;
            new_hi = hi;
            for (s = 0; s < SLOTS; s++) begin
                if (overlaps_slot(s, lo, hi)) begin
                    if (tbl_lo[s] < new_lo) new_lo = tbl_lo[s];
                    if (tbl_hi[s] > new_hi) new_hi = tbl_hi[s];
                    ids_covered = ids_covered - id_span(tbl_lo[s], tbl_hi[s]);
                    tbl_used[s] = 1'b0;
                    n_entries = n_entries - 9'd1;
                end
            end
            free_slot = -1;
            for (s = 0; s < SLOTS; s++) begin
                if (!tbl_used[s] && free_slot < 0) free_slot = s;
            end
            if (free_slot < 0) begin
                st = ST_FULL;
            end else begin
                tbl_lo[free_slot] = new_lo;
                tbl_hi[free_slot] = new_hi;
                tbl_used[free_slot] = 1'b1;
                n_entries = n_entries + 9'd1;
                ids_covered = ids_covered + id_span(new_lo, new_hi);
                st = ST_OK;
            end
        end
        rep.covered_total = ids_covered;
        rep.entry_count = n_entries;
        rep.status = st;
    endtask

    task automatic send_request(input logic [47:0] lo, input logic [47:0] hi);
        t_in  req;
        t_out rep;
        int   gap;
        req.range_low = lo;
        req.range_high = hi;
        i_in_valid <= 1'b1;
        i_in_data <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        merge_request(req, rep);
        pending_reports = {pending_reports, rep};
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_in_valid <= 1'b0;
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 300) : $urandom_range(1, 6);
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(0, 15);
        end
    endtask

    task automatic test_touch_and_merge();
        // touching neighbors stay apart, shared endpoints merge
        send_request(48'd0, 48'd0);
        send_request(48'd1, 48'd1);
        send_request(48'd3, 48'd5);
        send_request(48'd2, 48'd2);
        send_request(48'd5, 48'd7);
        send_request(48'd0, 48'd3);
        // one request bridging three entries, freed slots get reused
        send_request(48'd20, 48'd30);
        send_request(48'd40, 48'd50);
        send_request(48'd60, 48'd70);
        send_request(48'd25, 48'd65);
        // contained and enclosing ranges
        send_request(48'd200, 48'd300);
        send_request(48'd250, 48'd260);
        send_request(48'd150, 48'd400);
    endtask

    task automatic test_reversed();
        send_request(48'd9, 48'd8);
        send_request(ID_MAX, 48'd0);
        send_request(48'd1, 48'd0);
    endtask

    task automatic test_extremes();
        send_request(ID_MAX, ID_MAX);
        send_request(ID_MAX - 48'd10, ID_MAX - 48'd1);
        send_request(ID_MAX - 48'd20, ID_MAX);
        send_request(48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA);
        send_request(48'h2AAA_AAAA_AAAA, 48'h2AAA_AAAA_AAAA);
    endtask

    task automatic test_random_mix(input int n_items);
        logic [47:0] a, b, base;
        int          k, left_in_window, kind;
        left_in_window = 0;
        base = '0;
        for (k = 0; k < n_items; k++) begin
            if (left_in_window == 0) begin
                left_in_window = $urandom_range(40, 90);
                case ($urandom_range(0, 2))
                    0: base = '0;
                    1: base = below_fill(rand_id());
                    default: base = ID_MAX - 48'h10_0000;
                endcase
            end
            left_in_window--;
            kind = $urandom_range(0, 99);
            if (kind < 8) begin
                a = rand_id();
                if (a == 0) a = 48'd1;
                b = rand_id() % a;
                send_request(a, b);
            end else if (kind < 14) begin
                a = below_fill(rand_id());
                b = below_fill(rand_id());
                if (a > b) send_request(b, a);
                else send_request(a, b);
            end else if (kind < 20) begin
                b = ID_MAX - 48'($urandom_range(0, 64));
                a = b - 48'($urandom_range(0, 64));
                send_request(a, b);
            end else begin
                a = base + 48'($urandom_range(0, 3000));
                b = a + (($urandom_range(0, 3) == 0) ? 48'd0 : 48'($urandom_range(0, 60)));
                send_request(a, b);
            end
        end
    endtask

    task automatic test_fill_to_capacity();
        int          slot_order [FILL_CELLS];
        int          i, j, tmp, k;
        logic [47:0] lo, hi;
        for (i = 0; i < FILL_CELLS; i++) slot_order[i] = i;
        for (i = FILL_CELLS - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = slot_order[i];
            slot_order[i] = slot_order[j];
            slot_order[j] = tmp;
        end
        i = 0;
        while (n_entries < SLOTS && i < FILL_CELLS) begin
            lo = FILL_BASE + 48'(slot_order[i]) * FILL_STRIDE
                 + 48'($urandom_range(0, 32767));
            hi = lo + 48'($urandom_range(0, 16383));
            if (!table_hit(lo, hi)) send_request(lo, hi);
            i++;
        end
        // hold around the full point: new ranges, merges, point hits, reversed
        for (k = 0; k < 30 && i < FILL_CELLS; k++) begin
            j = $urandom_range(0, SLOTS - 1);
            while (!tbl_used[j]) j = $urandom_range(0, SLOTS - 1);
            case ($urandom_range(0, 3))
                0: begin
                    lo = FILL_BASE + 48'(slot_order[i]) * FILL_STRIDE
                         + 48'($urandom_range(0, 32767));
                    send_request(lo, lo + 48'($urandom_range(0, 16383)));
                    i++;
                end
                1: begin
                    hi = (tbl_hi[j] > ID_MAX - FILL_STRIDE) ? tbl_hi[j] : tbl_hi[j] + FILL_STRIDE;
                    send_request(tbl_lo[j], hi);
                end
                2: send_request(tbl_lo[j], tbl_lo[j]);
                default: send_request(tbl_hi[j], tbl_lo[j] - 48'd1);
            endcase
        end
    endtask

    task automatic test_collapse_all();
        logic [47:0] a, b;
        int          k;
        send_request(48'd0, ID_MAX);
        send_request(ID_MAX, ID_MAX);
        send_request(48'd0, 48'd0);
        send_request(ID_MAX, ID_MAX - 48'd1);
        for (k = 0; k < 4; k++) begin
            a = rand_id();
            b = rand_id();
            send_request(a, b);
        end
    endtask

    // receiver stall pattern: short and long stalls between free-running stretches
    always @(posedge i_clk) begin
        if (stall_run == 0) begin
            stall_on = ($urandom_range(0, 2) == 0);
            if (stall_on)
                stall_run = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 400)
                                                        : $urandom_range(1, 12);
            else
                stall_run = $urandom_range(1, 500);
        end
        stall_run--;
        i_out_stall <= stall_on;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got_report = o_out_data;
            if (pending_reports.size() == 0) begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected result: total=%0d count=%0d status=%0d",
                             got_report.covered_total, got_report.entry_count,
                             got_report.status);
            end else if (pending_reports[0].covered_total != got_report.covered_total ||
                         pending_reports[0].entry_count != got_report.entry_count ||
                         pending_reports[0].status != got_report.status) begin
                err_count++;
                if (err_count <= 10)
                    $display("result mismatch: expected total=%0d count=%0d status=%0d,",
                             pending_reports[0].covered_total, pending_reports[0].entry_count,
                             pending_reports[0].status,
                             " got total=%0d count=%0d status=%0d",
                             got_report.covered_total, got_report.entry_count,
                             got_report.status);
                void'(pending_reports.pop_front());
            end else begin
                void'(pending_reports.pop_front());
            end
        end
    end

    // watchdog on cycles where neither side moves a request or result
    always @(posedge i_clk) begin
        if ((i_rst_n && i_in_valid && !o_in_stall) || (i_rst_n && o_out_valid && !i_out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_touch_and_merge();
        test_reversed();
        test_extremes();
        test_random_mix(470);
        test_fill_to_capacity();
        test_collapse_all();
        i_in_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (err_count == 0 && pending_reports.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
